// ----- hdl/bol_pkg.sv -----
// Shared types, codes and default sizes for the bounded ordered list.
// Used by bol_cell and bounded_ordered_list; depends on nothing else.
package bol_pkg;

    localparam int DEFAULT_CAPACITY  = 8;
    localparam int DEFAULT_WORD_BITS = 32;
    localparam int ACTION_BITS       = 3;
    localparam int VALUE_BITS        = 32;
    localparam int STATUS_BITS       = 2;
    localparam int DATA_BITS         = 32;

    // Request actions.
    localparam logic [ACTION_BITS-1:0] ACT_APPEND   = 3'd0;
    localparam logic [ACTION_BITS-1:0] ACT_PREPEND  = 3'd1;
    localparam logic [ACTION_BITS-1:0] ACT_DELETE   = 3'd2;
    localparam logic [ACTION_BITS-1:0] ACT_CONTAINS = 3'd3;
    localparam logic [ACTION_BITS-1:0] ACT_READ_ALL = 3'd4;

    // Response status codes.
    localparam logic [STATUS_BITS-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] STAT_FULL      = 2'd1;
    localparam logic [STATUS_BITS-1:0] STAT_NOT_FOUND = 2'd2;

    // Commands broadcast to every cell of the chain.
    localparam logic [2:0] CMD_HOLD    = 3'd0;
    localparam logic [2:0] CMD_APPEND  = 3'd1;
    localparam logic [2:0] CMD_PREPEND = 3'd2;
    localparam logic [2:0] CMD_DELETE  = 3'd3;
    localparam logic [2:0] CMD_ROTATE  = 3'd4;

    typedef struct packed {
        logic [2:0] cmd;
    } bol_ctl_t;

    // Where a cell sits relative to the current fill level.
    typedef struct packed {
        logic occ;   // cell holds a live entry
        logic tail;  // first free cell
        logic last;  // highest live entry
    } bol_pos_t;

endpackage

// ----- hdl/bol_cell.sv -----
// One storage cell of the list chain: holds one entry and moves it to or
// from its neighbors under the broadcast command. Depends on bol_pkg.
module bol_cell
    import bol_pkg::*;
#(
    parameter int WORD_BITS = DEFAULT_WORD_BITS
)
(
    input  logic                 clk,
    input  bol_ctl_t             ctl,
    input  bol_pos_t             pos,
    input  logic [WORD_BITS-1:0] word,
    input  logic [WORD_BITS-1:0] head,
    input  logic [WORD_BITS-1:0] left_data,
    input  logic [WORD_BITS-1:0] right_data,
    input  logic                 seen_in,
    output logic                 seen_out,
    output logic [WORD_BITS-1:0] data
);

    logic [WORD_BITS-1:0] data_reg;
    logic [WORD_BITS-1:0] data_next;
    logic                 match;

    // A match here or anywhere below tells higher cells to close the gap.
    assign match    = pos.occ && (data_reg == word);
    assign seen_out = seen_in | match;
    assign data     = data_reg;

    always_comb
    begin
        data_next = data_reg;
        case (ctl.cmd)
            CMD_APPEND:
            begin
                if (pos.tail)
                begin
                    data_next = word;
                end
            end
            CMD_PREPEND:
            begin
                data_next = left_data;
            end
            CMD_DELETE:
            begin
                if (seen_out)
                begin
                    data_next = right_data;
                end
            end
            CMD_ROTATE:
            begin
                data_next = pos.last ? head : right_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// ----- hdl/bounded_ordered_list.sv -----
// Bounded ordered list: a chain of CAPACITY cells holding words in order.
// Depends on bol_pkg and bol_cell.
//
// Append, prepend, delete and contains each take one request beat and give
// one response beat in the next cycle; a new request can be taken every
// cycle as long as the response side keeps up, since the output register
// frees its slot in the same cycle its beat is taken. All cells compare
// against the request word at once and shift toward or away from the head
// together. Read all gives count response beats, one per cycle unless
// stalled, because the chain rotates one place per cycle and the head cell
// feeds the output register; after count rotations the list is back in its
// original order. During read all no request is taken, so a read all
// occupies the block until its last beat is in the output register, stalls
// included. A read all on an empty list, a delete or contains with no match,
// and an undefined action each give a single not-found beat; append or
// prepend on a full list gives one full beat and leaves the list as it was.
// Entries are stored in WORD_BITS bits (the low bits of the request value)
// and come back zero extended or cut to the 32-bit data port.
module bounded_ordered_list
    import bol_pkg::*;
#(
    parameter int CAPACITY  = DEFAULT_CAPACITY,
    parameter int WORD_BITS = DEFAULT_WORD_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic        [ACTION_BITS-1:0] action,
    input  logic signed [VALUE_BITS-1:0]  value,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic        [STATUS_BITS-1:0] status,
    output logic signed [DATA_BITS-1:0]   data,
    output logic                          data_valid,
    output logic                          last
);

    localparam int CW = $clog2(CAPACITY + 1);

    // Control state.
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          rd_busy_reg;
    logic          rd_busy_next;
    logic [CW-1:0] rd_left_reg;
    logic [CW-1:0] rd_left_next;
    logic          rsp_valid_reg;
    logic          rsp_valid_next;

    // Output payload register.
    logic [STATUS_BITS-1:0] status_reg;
    logic [STATUS_BITS-1:0] status_next;
    logic [DATA_BITS-1:0]   data_reg;
    logic [DATA_BITS-1:0]   data_next;
    logic                   data_valid_reg;
    logic                   data_valid_next;
    logic                   last_reg;
    logic                   last_next;

    logic                 req_fire;
    logic                 slot_free;
    logic                 list_full;
    logic                 found;
    logic [WORD_BITS-1:0] word;
    bol_ctl_t             ctl;

    logic [WORD_BITS-1:0] cell_data [CAPACITY];
    logic [CAPACITY:0]    seen;

    // Only the low WORD_BITS bits of the value are stored and compared.
    assign word = WORD_BITS'($unsigned(value));

    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign req_ready = !rd_busy_reg && slot_free;
    assign req_fire  = req_valid && req_ready;
    assign list_full = (count_reg == CW'(CAPACITY));
    assign found     = seen[CAPACITY];

    // The chain. Cell 0 is the head; a prepend feeds the request word into
    // it from the left, and the top cell re-reads itself from the right.
    assign seen[0] = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        bol_pos_t             pos;
        logic [WORD_BITS-1:0] left_data;
        logic [WORD_BITS-1:0] right_data;

        assign pos.occ  = (CW'(i) < count_reg);
        assign pos.tail = (count_reg == CW'(i));
        assign pos.last = (count_reg == CW'(i + 1));

        if (i == 0)
        begin : g_first
            assign left_data = word;
        end
        else
        begin : g_inner
            assign left_data = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_top
            assign right_data = cell_data[i];
        end
        else
        begin : g_below
            assign right_data = cell_data[i+1];
        end

        bol_cell #(
            .WORD_BITS (WORD_BITS)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .pos        (pos),
            .word       (word),
            .head       (cell_data[0]),
            .left_data  (left_data),
            .right_data (right_data),
            .seen_in    (seen[i]),
            .seen_out   (seen[i+1]),
            .data       (cell_data[i])
        );
    end

    // Sequencing. A pending read-all stream has priority over new requests;
    // requests are blocked while it runs anyway.
    always_comb
    begin
        count_next      = count_reg;
        rd_busy_next    = rd_busy_reg;
        rd_left_next    = rd_left_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        status_next     = status_reg;
        data_next       = data_reg;
        data_valid_next = data_valid_reg;
        last_next       = last_reg;
        ctl.cmd         = CMD_HOLD;

        if (rd_busy_reg && slot_free)
        begin
            // Emit the head entry and rotate the live part of the chain.
            ctl.cmd         = CMD_ROTATE;
            rsp_valid_next  = 1'b1;
            status_next     = STAT_OK;
            data_next       = DATA_BITS'(cell_data[0]);
            data_valid_next = 1'b1;
            last_next       = (rd_left_reg == CW'(1));
            rd_left_next    = rd_left_reg - CW'(1);
            rd_busy_next    = (rd_left_reg != CW'(1));
        end
        else if (req_fire)
        begin
            rsp_valid_next  = 1'b1;
            status_next     = STAT_NOT_FOUND;
            data_next       = '0;
            data_valid_next = 1'b0;
            last_next       = 1'b1;
            case (action)
                ACT_APPEND, ACT_PREPEND:
                begin
                    if (list_full)
                    begin
                        status_next = STAT_FULL;
                    end
                    else
                    begin
                        ctl.cmd     = (action == ACT_APPEND) ? CMD_APPEND : CMD_PREPEND;
                        count_next  = count_reg + CW'(1);
                        status_next = STAT_OK;
                    end
                end
                ACT_DELETE:
                begin
                    if (found)
                    begin
                        ctl.cmd     = CMD_DELETE;
                        count_next  = count_reg - CW'(1);
                        status_next = STAT_OK;
                    end
                end
                ACT_CONTAINS:
                begin
                    if (found)
                    begin
                        status_next = STAT_OK;
                    end
                end
                ACT_READ_ALL:
                begin
                    if (count_reg != '0)
                    begin
                        // Beats follow from the rotation stream.
                        rsp_valid_next = 1'b0;
                        rd_busy_next   = 1'b1;
                        rd_left_next   = count_reg;
                    end
                end
                default:
                begin
                    status_next = STAT_NOT_FOUND;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rd_busy_reg   <= 1'b0;
            rd_left_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rd_busy_reg   <= rd_busy_next;
            rd_left_reg   <= rd_left_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg     <= status_next;
        data_reg       <= data_next;
        data_valid_reg <= data_valid_next;
        last_reg       <= last_next;
    end

    assign rsp_valid  = rsp_valid_reg;
    assign status     = status_reg;
    assign data       = $signed(data_reg);
    assign data_valid = data_valid_reg;
    assign last       = last_reg;

`ifndef SYNTHESIS
    // The fill level never passes the capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("list count exceeds capacity");

    // A running read-all stream has beats left and no more than the list holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_busy_reg |-> (rd_left_reg != '0) && (rd_left_reg <= count_reg))
        else $error("read-all beat counter out of range");

    // The list does not change size while it is being streamed out.
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_busy_reg |=> count_reg == $past(count_reg))
        else $error("count changed during read-all");
`endif

endmodule

// ----- tb/bol_list_checker.sv -----
// Passive checker for the bounded ordered list: predicts the response beats of
// every accepted request and compares them with the beats the block gives.
// Depends on bol_pkg only.
module bol_list_checker
    import bol_pkg::*;
#(
    parameter int CAPACITY  = DEFAULT_CAPACITY,
    parameter int WORD_BITS = DEFAULT_WORD_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    input  logic                   req_ready,
    input  logic [ACTION_BITS-1:0] action,
    input  logic [VALUE_BITS-1:0]  value,
    input  logic                   rsp_valid,
    input  logic                   rsp_ready,
    input  logic [STATUS_BITS-1:0] status,
    input  logic [DATA_BITS-1:0]   data,
    input  logic                   data_valid,
    input  logic                   last,
    output int                     errors,
    output int                     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [DATA_BITS-1:0] WORD_MASK = (WORD_BITS >= DATA_BITS) ?
        {DATA_BITS{1'b1}} : DATA_BITS'((64'd1 << WORD_BITS) - 64'd1);

    typedef struct {
        logic [STATUS_BITS-1:0] code;
        logic [DATA_BITS-1:0]   word;
        logic                   holds_word;
        logic                   closes;
    } list_reply_t;

    logic [DATA_BITS-1:0] slots [CAPACITY];
    int                   fill = 0;
    list_reply_t          reply_q [$];
    int                   mismatches = 0;

    task automatic report_mismatch(input string what, input logic [DATA_BITS-1:0] got,
                                   input logic [DATA_BITS-1:0] want);
        mismatches++;
        $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
    endtask

    function automatic void push_reply(input logic [STATUS_BITS-1:0] code,
                                       input logic [DATA_BITS-1:0] word,
                                       input logic holds_word, input logic closes);
        list_reply_t r;
        r.code       = code;
        r.word       = word;
        r.holds_word = holds_word;
        r.closes     = closes;
        reply_q.insert(reply_q.size(), r);
    endfunction

    function automatic int find_slot(input logic [DATA_BITS-1:0] word);
        for (int i = 0; i < fill; i++)
            if (slots[i] == word)
                return i;
        return -1;
    endfunction

    // Updates the list copy for one request and queues the beats it should give.
    function automatic void apply_request(input logic [ACTION_BITS-1:0] act,
                                          input logic [VALUE_BITS-1:0] val);
        logic [DATA_BITS-1:0] word;
        int                   hit;
        word = DATA_BITS'(val) & WORD_MASK;
        case (act)
            ACT_APPEND, ACT_PREPEND:
            begin
                if (fill >= CAPACITY)
                begin
                    push_reply(STAT_FULL, '0, 1'b0, 1'b1);
                end
                else
                begin
                    if (act == ACT_APPEND)
                    begin
                        slots[fill] = word;
                    end
                    else
                    begin
                        for (int i = fill; i > 0; i--)
                            slots[i] = slots[i-1];
                        slots[0] = word;
                    end
                    fill++;
                    push_reply(STAT_OK, '0, 1'b0, 1'b1);
                end
            end
            ACT_DELETE:
            begin
                hit = find_slot(word);
                if (hit < 0)
                begin
                    push_reply(STAT_NOT_FOUND, '0, 1'b0, 1'b1);
                end
                else
                begin
                    for (int i = hit; i + 1 < fill; i++)
                        slots[i] = slots[i+1];
                    fill--;
                    push_reply(STAT_OK, '0, 1'b0, 1'b1);
                end
            end
            ACT_CONTAINS:
            begin
                hit = find_slot(word);
                push_reply((hit < 0) ? STAT_NOT_FOUND : STAT_OK, '0, 1'b0, 1'b1);
            end
            ACT_READ_ALL:
            begin
                if (fill == 0)
                    push_reply(STAT_NOT_FOUND, '0, 1'b0, 1'b1);
                for (int i = 0; i < fill; i++)
                    push_reply(STAT_OK, slots[i], 1'b1, (i + 1 == fill));
            end
            default:
            begin
                push_reply(STAT_NOT_FOUND, '0, 1'b0, 1'b1);
            end
        endcase
    endfunction

    // Responses are checked before the request of the same edge is predicted,
    // since a request never answers in the cycle it is taken.
    always @(posedge clk or negedge rst_n)
    begin
        list_reply_t head;
        if (!rst_n)
        begin
            fill = 0;
            reply_q.delete();
        end
        else
        begin
            if (rsp_valid === 1'b1 && rsp_ready === 1'b1)
            begin
                if (reply_q.size() == 0)
                begin
                    report_mismatch("response beat with nothing outstanding, status",
                                    DATA_BITS'(status), '0);
                end
                else
                begin
                    head = reply_q.pop_front();
                    if (status !== head.code)
                        report_mismatch("status", DATA_BITS'(status), DATA_BITS'(head.code));
                    if (data !== head.word)
                        report_mismatch("data", data, head.word);
                    if (data_valid !== head.holds_word)
                        report_mismatch("data_valid", DATA_BITS'(data_valid),
                                        DATA_BITS'(head.holds_word));
                    if (last !== head.closes)
                        report_mismatch("last", DATA_BITS'(last), DATA_BITS'(head.closes));
                end
            end
            if (req_valid === 1'b1 && req_ready === 1'b1)
                apply_request(action, value);
        end
        pending <= reply_q.size();
        errors  <= mismatches;
    end

endmodule

// ----- tb/tb_bounded_ordered_list.sv -----
// Top of the bounded ordered list testbench: clock, reset, request stimulus
// and response back-pressure around the block, with bol_list_checker doing
// the prediction and comparison. Depends on bol_pkg, bounded_ordered_list, bol_list_checker.
module tb_bounded_ordered_list
    import bol_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 4;
    localparam int RESET_CYCLES  = 11;
    // Random requests after the directed opening; the last stretch of them
    // runs with neither side idling.
    localparam int RANDOM_ITEMS  = 286;
    localparam int QUIET_ITEMS   = 40;
    // Fill and drain phases alternate every this many random requests.
    localparam int PHASE_ITEMS   = 30;
    // The long response hold-off starts once this many requests have gone in.
    localparam int HOLD_AT_ITEM  = 120;
    localparam int HOLD_CYCLES   = 60;
    // A full read all gives CAPACITY beats, so this leaves ample margin for
    // any stray beat to show up after the last expected one.
    localparam int DRAIN_CYCLES  = 32;

    // Action codes the block does not define; they must answer not found.
    localparam logic [ACTION_BITS-1:0] ACT_UNUSED_FIRST = ACT_READ_ALL + 1'b1;
    localparam logic [ACTION_BITS-1:0] ACT_UNUSED_LAST  = '1;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          req_valid;
    logic                          req_ready;
    logic        [ACTION_BITS-1:0] action;
    logic signed [VALUE_BITS-1:0]  value;
    logic                          rsp_valid;
    logic                          rsp_ready;
    logic        [STATUS_BITS-1:0] status;
    logic signed [DATA_BITS-1:0]   data;
    logic                          data_valid;
    logic                          last;

    int errors;
    int pending;

    // Stimulus progress, shared with the response process so that it knows
    // when to start the long hold-off and when to stop idling.
    int beats_sent = 0;
    bit quiet      = 1'b0;
    bit hold_done  = 1'b0;

    // Values that random requests mostly draw from, so that delete and
    // contains find matches often and duplicates appear in the list.
    logic [VALUE_BITS-1:0] value_pool [8];

    always #(CLK_PERIOD / 2) clk = ~clk;

    bounded_ordered_list dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .action     (action),
        .value      (value),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .status     (status),
        .data       (data),
        .data_valid (data_valid),
        .last       (last)
    );

    bol_list_checker list_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .action     (action),
        .value      (value),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .status     (status),
        .data       (data),
        .data_valid (data_valid),
        .last       (last),
        .errors     (errors),
        .pending    (pending)
    );

    // Offers one request beat and returns at the edge where it is taken, or after an idle gap that may follow.
    // Valid is raised here and kept high through any wait; it only drops when
    // an idle burst follows, so back-to-back beats never toggle it within one
    // time step. Outputs are sampled right after the edge, before any of the
    // edge's nonblocking updates land.
    task automatic send_beat(input logic [ACTION_BITS-1:0] act,
                             input logic [VALUE_BITS-1:0] val);
        int gap;
        req_valid <= 1'b1;
        action    <= act;
        value     <= val;
        do
            @(posedge clk);
        while (req_ready !== 1'b1);
        beats_sent++;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 4);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [VALUE_BITS-1:0] pick_value();
        if ($urandom_range(0, 9) < 7)
            return value_pool[$urandom_range(0, 7)];
        return $urandom();
    endfunction

    // Fill phases favor inserts so that the list reaches full; drain phases
    // favor deletes so that it runs empty again. Read all and the undefined
    // codes show up in both.
    function automatic logic [ACTION_BITS-1:0] pick_action(input bit filling);
        int roll;
        roll = $urandom_range(0, 99);
        if (filling)
        begin
            if (roll < 35) return ACT_APPEND;
            if (roll < 60) return ACT_PREPEND;
            if (roll < 72) return ACT_DELETE;
            if (roll < 84) return ACT_CONTAINS;
            if (roll < 96) return ACT_READ_ALL;
        end
        else
        begin
            if (roll < 12) return ACT_APPEND;
            if (roll < 22) return ACT_PREPEND;
            if (roll < 57) return ACT_DELETE;
            if (roll < 77) return ACT_CONTAINS;
            if (roll < 96) return ACT_READ_ALL;
        end
        return ACTION_BITS'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
    endfunction

    // Request side: reset, the directed opening, then the random body.
    initial
    begin
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        action    <= ACT_APPEND;
        value     <= '0;
        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hFFFF_FFFF;
        value_pool[2] = 32'h7FFF_FFFF;
        value_pool[3] = 32'h8000_0000;
        for (int i = 4; i < 8; i++)
            value_pool[i] = $urandom();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The empty list: read all, delete and contains all answer not found.
        send_beat(ACT_READ_ALL, 32'h0000_0000);
        send_beat(ACT_DELETE, 32'h0000_0005);
        send_beat(ACT_CONTAINS, 32'h0000_0005);
        // Extreme words at both ends, including a duplicate of the largest.
        send_beat(ACT_APPEND, 32'h7FFF_FFFF);
        send_beat(ACT_PREPEND, 32'h8000_0000);
        send_beat(ACT_APPEND, 32'h0000_0000);
        send_beat(ACT_PREPEND, 32'hFFFF_FFFF);
        send_beat(ACT_CONTAINS, 32'h0000_0000);
        send_beat(ACT_CONTAINS, 32'h0001_2345);
        send_beat(ACT_APPEND, 32'h7FFF_FFFF);
        send_beat(ACT_APPEND, 32'h0000_0001);
        send_beat(ACT_APPEND, 32'h0000_0002);
        send_beat(ACT_APPEND, 32'h0000_0003);
        // The list is full now: both inserts are refused and a read all
        // gives the longest burst of beats.
        send_beat(ACT_APPEND, 32'h0000_0004);
        send_beat(ACT_PREPEND, 32'h0000_0004);
        send_beat(ACT_READ_ALL, 32'hFFFF_FFFF);
        // Delete the first of two equal words, then the head, then the
        // tail, then a word that is not there.
        send_beat(ACT_DELETE, 32'h7FFF_FFFF);
        send_beat(ACT_DELETE, 32'hFFFF_FFFF);
        send_beat(ACT_DELETE, 32'h0000_0003);
        send_beat(ACT_DELETE, 32'h0000_0063);
        // Undefined codes leave the list alone.
        send_beat(ACT_UNUSED_FIRST, 32'h0000_0000);
        send_beat(ACT_UNUSED_FIRST + 1'b1, 32'h7FFF_FFFF);
        send_beat(ACT_UNUSED_LAST, 32'h8000_0000);
        send_beat(ACT_READ_ALL, 32'h0000_0000);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
            send_beat(pick_action((i / PHASE_ITEMS) % 2 == 0), pick_value());
        end
        req_valid <= 1'b0;

        // One edge first so that the count of outstanding beats includes the
        // request taken last.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("bounded_ordered_list verification clean");
        else
            $display("bounded_ordered_list verification failed");
        $finish;
    end

    // Response side: random ready bursts, one long hold-off in the middle of
    // the run so that the output backs up and the block stops taking
    // requests, and ready held high for the quiet tail.
    initial
    begin
        rsp_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (quiet)
            begin
                rsp_ready <= 1'b1;
                @(posedge clk);
            end
            else if (!hold_done && beats_sent >= HOLD_AT_ITEM)
            begin
                hold_done = 1'b1;
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            else
            begin
                rsp_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // Watchdog. A correct run needs well under a fifth of this even with every
    // read all at full length and every beat stalled.
    initial
    begin
        #400us;
        $display("bounded_ordered_list verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/bol_pkg.sv
hdl/bol_cell.sv
hdl/bounded_ordered_list.sv
tb/bol_list_checker.sv
tb/tb_bounded_ordered_list.sv
